@@ rtl/lfu_pkg.sv @@
// lfu page replacement package: shared widths, controller states and command/status structs
`timescale 1ns / 1ps

package lfu_pkg;

   localparam int PAGE_W  = 6;
   localparam int SLOT_W  = 3;
   localparam int FAULT_W = 32;
   localparam int STAMP_W = 32;
   localparam int CFG_W   = 4;
   localparam int APB_W   = 32;
   localparam int ADDR_W  = 3;

   localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

   // register index decoded from paddr[2]
   localparam logic REG_FRAMES_IN_USE = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUMP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_VIC_FRAME,
      ST_VIC_PAGE,
      ST_VIC_CMP,
      ST_FILL,
      ST_HIT,
      ST_EVICT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic bump;
      logic scan_next;
      logic vic_start;
      logic vic_page;
      logic vic_compare;
      logic vic_next;
      logic fin_fill;
      logic fin_hit;
      logic fin_evict;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic frame_empty;
      logic frame_match;
      logic last_frame;
      logic out_free;
   } status_type;

endpackage

@@ rtl/lfu_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface lfu_req_if;
   logic                        valid;
   logic                        ready;
   logic [lfu_pkg::PAGE_W-1:0]  page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lfu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [lfu_pkg::SLOT_W-1:0]  slot;
   logic                        evicted_valid;
   logic [lfu_pkg::PAGE_W-1:0]  evicted_page;
   logic [lfu_pkg::FAULT_W-1:0] fault_total;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input slot, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

@@ rtl/lfu_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/lfu_ctrl.sv @@
// controller state machine: clear pass, lookup scan, victim search, result hand-off
`timescale 1ns / 1ps

module lfu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lfu_pkg::status_type status,
   output lfu_pkg::cmd_type    cmd
);

   lfu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfu_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = lfu_pkg::ST_IDLE;
         end
         lfu_pkg::ST_IDLE: begin
            if (req_valid) state_in = lfu_pkg::ST_BUMP;
         end
         lfu_pkg::ST_BUMP: begin
            state_in = lfu_pkg::ST_SCAN_RD;
         end
         lfu_pkg::ST_SCAN_RD: begin
            state_in = lfu_pkg::ST_SCAN_CHK;
         end
         lfu_pkg::ST_SCAN_CHK: begin
            if (status.frame_empty) state_in = lfu_pkg::ST_FILL;
            else if (status.frame_match) state_in = lfu_pkg::ST_HIT;
            else if (status.last_frame) state_in = lfu_pkg::ST_VIC_FRAME;
            else state_in = lfu_pkg::ST_SCAN_RD;
         end
         lfu_pkg::ST_VIC_FRAME: begin
            state_in = lfu_pkg::ST_VIC_PAGE;
         end
         lfu_pkg::ST_VIC_PAGE: begin
            state_in = lfu_pkg::ST_VIC_CMP;
         end
         lfu_pkg::ST_VIC_CMP: begin
            if (status.last_frame) state_in = lfu_pkg::ST_EVICT;
            else state_in = lfu_pkg::ST_VIC_FRAME;
         end
         lfu_pkg::ST_FILL, lfu_pkg::ST_HIT, lfu_pkg::ST_EVICT: begin
            if (status.out_free) state_in = lfu_pkg::ST_IDLE;
         end
         default: begin
            state_in = lfu_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lfu_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         lfu_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         lfu_pkg::ST_BUMP: begin
            cmd.bump = 1'b1;
         end
         lfu_pkg::ST_SCAN_CHK: begin
            if (!status.frame_empty && !status.frame_match) begin
               if (status.last_frame) cmd.vic_start = 1'b1;
               else cmd.scan_next = 1'b1;
            end
         end
         lfu_pkg::ST_VIC_PAGE: begin
            cmd.vic_page = 1'b1;
         end
         lfu_pkg::ST_VIC_CMP: begin
            cmd.vic_compare = 1'b1;
            cmd.vic_next    = !status.last_frame;
         end
         lfu_pkg::ST_FILL: begin
            cmd.fin_fill = status.out_free;
         end
         lfu_pkg::ST_HIT: begin
            cmd.fin_hit = status.out_free;
         end
         lfu_pkg::ST_EVICT: begin
            cmd.fin_evict = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/lfu_dp.sv @@
// datapath: page map, count and stamp memories, frame table, victim tracking, result register
`timescale 1ns / 1ps

module lfu_dp #(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_COUNT = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lfu_pkg::cmd_type             cmd,
   output lfu_pkg::status_type          status,
   input  logic [lfu_pkg::CFG_W-1:0]    frames_in_use,
   input  logic [lfu_pkg::PAGE_W-1:0]   req_page,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [lfu_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_evicted_valid,
   output logic [lfu_pkg::PAGE_W-1:0]   rsp_evicted_page,
   output logic [lfu_pkg::FAULT_W-1:0]  rsp_fault_total
);

   localparam int PW      = PAGE_COUNT > 1 ? $clog2(PAGE_COUNT) : 1;
   localparam int FW      = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
   localparam int CW      = COUNT_BITS;
   localparam int PgW     = lfu_pkg::PAGE_W;
   localparam int SlW     = lfu_pkg::SLOT_W;
   localparam int FltW    = lfu_pkg::FAULT_W;
   localparam int StW     = lfu_pkg::STAMP_W;
   localparam int CfgW    = lfu_pkg::CFG_W;
   localparam int MapSize = 2 ** lfu_pkg::PAGE_W;
   localparam logic [7:0] MaxFr = 8'(MAX_FRAMES);

   // page number folded into the store
   logic [PW-1:0] page_map [MapSize];

   for (genvar g = 0; g < MapSize; g++) begin : g_map
      assign page_map[g] = PW'(g % PAGE_COUNT);
   end

   logic [PW-1:0]   req_pg;
   logic [PW-1:0]   pg_ff;
   logic [PW-1:0]   clr_ff;
   logic [FW-1:0]   j_ff;
   logic [FW-1:0]   last_idx;
   logic [7:0]      fiu8;
   logic [7:0]      last8;
   logic [MAX_FRAMES-1:0] fvalid_ff;
   logic [StW-1:0]  ref_ff;
   logic [FltW-1:0] fault_ff;
   logic [FltW-1:0] fault_inc;

   logic [PW-1:0]   cand_page_ff;
   logic [FW-1:0]   best_idx_ff;
   logic [PW-1:0]   best_page_ff;
   logic [CW-1:0]   best_cnt_ff;
   logic [StW-1:0]  best_stamp_ff;
   logic            take;

   logic            cnt_we;
   logic [PW-1:0]   cnt_waddr;
   logic [CW-1:0]   cnt_wdata;
   logic [PW-1:0]   cnt_raddr;
   logic [CW-1:0]   cnt_rdata;
   logic [CW-1:0]   cnt_inc;
   logic [StW-1:0]  stamp_rdata;
   logic            fr_we;
   logic [FW-1:0]   fr_waddr;
   logic [PW-1:0]   fr_rdata;

   logic            rsp_valid_ff;
   logic            hit_ff;
   logic [SlW-1:0]  slot_ff;
   logic            ev_valid_ff;
   logic [PgW-1:0]  ev_page_ff;
   logic [FltW-1:0] fault_total_ff;
   logic            fin_any;

   assign req_pg = page_map[req_page];

   // frame count of zero acts as one, above the table size acts as the table size
   assign fiu8  = {{(8 - CfgW){1'b0}}, frames_in_use};
   assign last8 = (fiu8 == 8'd0) ? 8'd0 : ((fiu8 > MaxFr) ? MaxFr - 8'd1 : fiu8 - 8'd1);
   assign last_idx = last8[FW-1:0];

   assign cnt_inc   = (cnt_rdata == {CW{1'b1}}) ? cnt_rdata : cnt_rdata + CW'(1);
   assign fault_inc = (fault_ff == {FltW{1'b1}}) ? fault_ff : fault_ff + FltW'(1);
   assign fin_any   = cmd.fin_fill | cmd.fin_hit | cmd.fin_evict;

   // use count store
   always_comb begin
      cnt_we    = cmd.clear_step | cmd.bump | cmd.fin_evict;
      cnt_waddr = best_page_ff;
      cnt_wdata = '0;
      if (cmd.clear_step) begin
         cnt_waddr = clr_ff;
      end else if (cmd.bump) begin
         cnt_waddr = pg_ff;
         cnt_wdata = cnt_inc;
      end
      cnt_raddr = cmd.accept ? req_pg : fr_rdata;
   end

   lfu_ram #(.WIDTH(CW), .DEPTH(PAGE_COUNT)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   lfu_ram #(.WIDTH(StW), .DEPTH(PAGE_COUNT)) u_stamp_ram (
      .clock (clock),
      .we    (cmd.bump),
      .waddr (pg_ff),
      .wdata (ref_ff),
      .raddr (fr_rdata),
      .rdata (stamp_rdata)
   );

   assign fr_we    = cmd.fin_fill | cmd.fin_evict;
   assign fr_waddr = cmd.fin_evict ? best_idx_ff : j_ff;

   lfu_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_frame_ram (
      .clock (clock),
      .we    (fr_we),
      .waddr (fr_waddr),
      .wdata (pg_ff),
      .raddr (j_ff),
      .rdata (fr_rdata)
   );

   // least count wins, ties to the older stamp, then the lower frame
   assign take = (j_ff == '0) || (cnt_rdata < best_cnt_ff) ||
                 ((cnt_rdata == best_cnt_ff) && (stamp_rdata < best_stamp_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         j_ff         <= '0;
         fvalid_ff    <= '0;
         ref_ff       <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + PW'(1);
         if (cmd.bump || cmd.vic_start) begin
            j_ff <= '0;
         end else if (cmd.scan_next || cmd.vic_next) begin
            j_ff <= j_ff + FW'(1);
         end
         if (cmd.bump) ref_ff <= ref_ff + StW'(1);
         if (cmd.fin_fill) fvalid_ff[j_ff] <= 1'b1;
         if (cmd.fin_fill || cmd.fin_evict) fault_ff <= fault_inc;
         if (fin_any) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) pg_ff <= req_pg;
      if (cmd.vic_page) cand_page_ff <= fr_rdata;
      if (cmd.vic_compare && take) begin
         best_idx_ff   <= j_ff;
         best_page_ff  <= cand_page_ff;
         best_cnt_ff   <= cnt_rdata;
         best_stamp_ff <= stamp_rdata;
      end
      if (fin_any) begin
         hit_ff         <= cmd.fin_hit;
         slot_ff        <= cmd.fin_evict ? SlW'(best_idx_ff) : SlW'(j_ff);
         ev_valid_ff    <= cmd.fin_evict;
         ev_page_ff     <= cmd.fin_evict ? PgW'(best_page_ff) : '0;
         fault_total_ff <= cmd.fin_hit ? fault_ff : fault_inc;
      end
   end

   assign status.clear_last  = (clr_ff == PW'(PAGE_COUNT - 1));
   assign status.frame_empty = !fvalid_ff[j_ff];
   assign status.frame_match = (fr_rdata == pg_ff);
   assign status.last_frame  = (j_ff == last_idx);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_fault_total   = fault_total_ff;

endmodule

@@ rtl/lfu_page_replacement.sv @@
// top level of the lfu page replacement block
//
//   channel   direction  handshake            payload
//   req_chan  in         valid / ready        page
//   rsp_chan  out        valid / ready        hit, slot, evicted_valid, evicted_page,
//                                             fault_total
//   csr_*     in         apb write, pready=1  frames_in_use at address 0
//
// one transaction at a time; a hit or fill at frame k scans frames 0 to k,
// a replacement with n frames in use scans all n frames, then searches them for a victim
// the frame scan has a read and a check state for each frame, and the victim search
// a frame, page and compare state through the frame, count and stamp memories
// after reset a clearing pass zeroes every entry of the count memory before
// the first request is taken
// a stalled result sits in the output register; the next request is taken meanwhile
`timescale 1ns / 1ps

module lfu_page_replacement #(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_COUNT = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   lfu_req_if.sink                       req_chan,
   lfu_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lfu_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [lfu_pkg::APB_W-1:0]     csr_pwdata,
   output logic [lfu_pkg::APB_W-1:0]     csr_prdata,
   output logic                          csr_pready
);

   localparam int CfgW = lfu_pkg::CFG_W;
   localparam int ApbW = lfu_pkg::APB_W;

   logic [CfgW-1:0]     frames_ff;
   logic                req_ready;
   logic                reg_sel;
   lfu_pkg::cmd_type    cmd;
   lfu_pkg::status_type status;

   assign reg_sel    = (csr_paddr[2] == lfu_pkg::REG_FRAMES_IN_USE);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? {{(ApbW - CfgW){1'b0}}, frames_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= lfu_pkg::FRAMES_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         frames_ff <= csr_pwdata[CfgW-1:0];
      end
   end

   assign req_chan.ready = req_ready;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_dp #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_COUNT (PAGE_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .frames_in_use     (frames_ff),
      .req_page          (req_chan.page),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_hit           (rsp_chan.hit),
      .rsp_slot          (rsp_chan.slot),
      .rsp_evicted_valid (rsp_chan.evicted_valid),
      .rsp_evicted_page  (rsp_chan.evicted_page),
      .rsp_fault_total   (rsp_chan.fault_total)
   );

endmodule

@@ rtl/lfu_chk.sv @@
// port-level checker for the lfu page replacement block, bound to the top level
`timescale 1ns / 1ps

module lfu_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_hit,
   input logic [lfu_pkg::SLOT_W-1:0]   rsp_slot,
   input logic                         rsp_evicted_valid,
   input logic [lfu_pkg::PAGE_W-1:0]   rsp_evicted_page,
   input logic [lfu_pkg::FAULT_W-1:0]  rsp_fault_total
);

   localparam int FltW = lfu_pkg::FAULT_W;

   logic [FltW-1:0] last_fault_ff;
   logic            rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_fault_ff <= '0;
      end else if (rsp_xfer) begin
         last_fault_ff <= rsp_fault_total;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit)
                                  && $stable(rsp_fault_total))
      else $error("result changed while stalled");

   // a hit replaces nothing
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("hit reported with an eviction");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page set without an eviction");

   // fault total moves by exactly one per miss transaction, saturating
   a_fault_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (rsp_hit && rsp_fault_total == last_fault_ff) ||
                   (!rsp_hit && rsp_fault_total == last_fault_ff + FltW'(1)) ||
                   (!rsp_hit && last_fault_ff == {FltW{1'b1}} &&
                    rsp_fault_total == last_fault_ff))
      else $error("fault total out of step");

endmodule

bind lfu_page_replacement lfu_chk u_lfu_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_hit           (rsp_chan.hit),
   .rsp_slot          (rsp_chan.slot),
   .rsp_evicted_valid (rsp_chan.evicted_valid),
   .rsp_evicted_page  (rsp_chan.evicted_page),
   .rsp_fault_total   (rsp_chan.fault_total)
);
